@@ rtl/subtbl_pkg.sv @@
// Shared types and constants for the subscriber table.
// Used by subtbl_cell and subscriber_table_with_id_lookup; no dependencies.
package subtbl_pkg;

	// slots are spread over a row of cells, slot i lives in cell i % CELLS
	localparam int CELLS  = 4;
	localparam int CELL_W = 2;

	localparam int ID_W   = 24;
	localparam int RESV_W = 34;
	localparam int PNUM_W = 8;

	localparam logic [31:0] PROFILE_ZERO_RESET = 32'd2191;

	// request kinds
	localparam logic [2:0] REQ_PUT_ENTRY   = 3'd0;
	localparam logic [2:0] REQ_GET_ENTRY   = 3'd1;
	localparam logic [2:0] REQ_LOOKUP      = 3'd2;
	localparam logic [2:0] REQ_PUT_PROFILE = 3'd3;
	localparam logic [2:0] REQ_GET_PROFILE = 3'd4;

	// result status
	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_INVALID       = 2'd1;
	localparam logic [1:0] ST_NOT_PERMITTED = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND     = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic              typ;
		logic [PNUM_W-1:0] pnum;
		logic [RESV_W-1:0] resv;
		logic              valid;
	} entry_t;

	// hit token passed from cell to cell during a lookup
	typedef struct packed {
		logic              found;
		logic [CELL_W-1:0] col;
	} chain_t;

endpackage

@@ rtl/subtbl_cell.sv @@
// One cell of the subscriber table: a bank of slots and the id compare.
// Depends on subtbl_pkg.
module subtbl_cell #(
	parameter int ROWS    = 256,
	parameter int ROW_W   = 8,
	parameter int CELL_ID = 0
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [ROW_W-1:0]                    wr_row,
	input  subtbl_pkg::entry_t                  wr_data,
	input  logic                                rd_en,
	input  logic [ROW_W-1:0]                    rd_row,
	output subtbl_pkg::entry_t                  rd_data,
	input  logic [subtbl_pkg::ID_W-1:0]         key,
	input  subtbl_pkg::chain_t                  chain_in,
	output subtbl_pkg::chain_t                  chain_out
);
	import subtbl_pkg::*;

	entry_t mem [ROWS];
	entry_t rd_q;
	logic   hit;

	// bank storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
	end

	assign rd_data = rd_q;
	assign hit     = rd_q.valid && (rd_q.id == key);

	// a lower cell's hit wins over ours
	always_comb begin
		if (chain_in.found) begin
			chain_out = chain_in;
		end else begin
			chain_out.found = hit;
			chain_out.col   = CELL_W'(CELL_ID);
		end
	end

endmodule

@@ rtl/subscriber_table_with_id_lookup.sv @@
// Channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | req_type .. profile_word
// out     | out | out_valid / out_ready| status .. read_profile_word
// cfg     | in  | cfg_valid / cfg_ready| cfg_data (profile zero word)
//
// One request at a time. Puts and range errors finish straight from idle, get entry
// and get profile pass through a read state (registered memory read), a lookup ends
// when a row hits or the last row is checked: one row of the four-cell chain is read per cycle.
// After reset a clearing pass writes zero to every row; in_ready stays low
// during it. A new request is taken once the previous result has been
// transferred.
// Top level of the subscriber table; depends on subtbl_pkg and subtbl_cell.
module subscriber_table_with_id_lookup #(
	parameter int ENTITIES = 1024,
	parameter int PROFILES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [15:0] entry_index,
	input  logic [31:0] subscriber_id,
	input  logic [7:0]  subscriber_type,
	input  logic [7:0]  profile_number,
	input  logic [33:0] reserved_bits,
	input  logic        entry_valid,
	input  logic [7:0]  profile_index,
	input  logic [31:0] profile_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] match_index,
	output logic [23:0] read_subscriber_id,
	output logic        read_subscriber_type,
	output logic [7:0]  read_profile_number,
	output logic [33:0] read_reserved,
	output logic        read_valid,
	output logic [31:0] read_profile_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import subtbl_pkg::*;

	localparam int ROWS  = (ENTITIES + CELLS - 1) / CELLS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PW    = (PROFILES > 1) ? $clog2(PROFILES) : 1;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_RDENT  = 5'b00100,
		S_RDPROF = 5'b01000,
		S_SCAN   = 5'b10000
	} state_t;

	state_t              state_q;
	logic [ROW_W:0]      clr_q;
	logic [ROW_W:0]      iss_q;
	logic [ROW_W-1:0]    chk_q;
	logic                chk_vld_q;
	logic [CELL_W-1:0]   sel_q;
	logic [ID_W-1:0]     key_q;
	logic                pzero_q;
	logic [31:0]         pz_word_q;

	logic [31:0]         prof_mem [PROFILES];
	logic [PROFILES-1:0] prof_vld_q;
	logic [31:0]         prof_rd_q;
	logic                prof_rd_vld_q;

	logic                out_valid_q;
	logic [1:0]          st_q;
	logic [15:0]         mi_q;
	entry_t              ent_q;
	logic [31:0]         pw_q;

	logic                acc;
	logic                idx_ok, pidx_ok, put_ok;
	logic [15:0]         row_full;
	logic [ROW_W-1:0]    in_row;
	logic [CELL_W-1:0]   in_cell;
	logic [PW-1:0]       pidx;

	logic [CELLS-1:0]    wr_en;
	logic [ROW_W-1:0]    wr_row;
	entry_t              wr_data;
	logic                rd_en;
	logic [ROW_W-1:0]    rd_row;
	entry_t              rd_data [CELLS];
	chain_t              chain [CELLS+1];

	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign acc       = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// request decode
	assign idx_ok   = {16'd0, entry_index} < 32'(ENTITIES);
	assign pidx_ok  = {24'd0, profile_index} < 32'(PROFILES);
	assign put_ok   = idx_ok && ({24'd0, profile_number} < 32'(PROFILES))
			&& (subscriber_type[7:1] == 7'd0) && (subscriber_id[31:24] == 8'd0);
	assign row_full = entry_index >> CELL_W;
	assign in_row   = row_full[ROW_W-1:0];
	assign in_cell  = entry_index[CELL_W-1:0];
	assign pidx     = profile_index[PW-1:0];

	// cell write and read ports
	always_comb begin
		wr_en   = '0;
		wr_row  = in_row;
		wr_data = '{id: subscriber_id[ID_W-1:0], typ: subscriber_type[0],
			pnum: profile_number, resv: reserved_bits, valid: entry_valid};
		rd_en   = 1'b0;
		rd_row  = in_row;
		if (state_q == S_CLEAR) begin
			wr_en   = '1;
			wr_row  = clr_q[ROW_W-1:0];
			wr_data = '0;
		end else if (acc && req_type == REQ_PUT_ENTRY && put_ok) begin
			wr_en[in_cell] = 1'b1;
		end
		if (acc && req_type == REQ_GET_ENTRY && idx_ok) begin
			rd_en = 1'b1;
		end else if (state_q == S_SCAN) begin
			rd_en  = iss_q < (ROW_W+1)'(ROWS);
			rd_row = iss_q[ROW_W-1:0];
		end
	end

	// the chain of cells
	assign chain[0] = '0;
	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		subtbl_cell #(
			.ROWS    (ROWS),
			.ROW_W   (ROW_W),
			.CELL_ID (c)
		) u_cell (
			.clk       (clk),
			.wr_en     (wr_en[c]),
			.wr_row    (wr_row),
			.wr_data   (wr_data),
			.rd_en     (rd_en),
			.rd_row    (rd_row),
			.rd_data   (rd_data[c]),
			.key       (key_q),
			.chain_in  (chain[c]),
			.chain_out (chain[c+1])
		);
	end

	// profile words, registered read
	always_ff @(posedge clk) begin
		if (acc && req_type == REQ_PUT_PROFILE && pidx_ok && pidx != '0) begin
			prof_mem[pidx] <= profile_word;
		end
		if (acc) begin
			prof_rd_q <= prof_mem[pidx];
		end
	end

	// profile written marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prof_vld_q    <= '0;
			prof_rd_vld_q <= 1'b0;
		end else if (acc) begin
			prof_rd_vld_q <= prof_vld_q[pidx];
			if (req_type == REQ_PUT_PROFILE && pidx_ok && pidx != '0) begin
				prof_vld_q[pidx] <= 1'b1;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pz_word_q <= PROFILE_ZERO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pz_word_q <= cfg_data;
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (acc) begin
			sel_q   <= in_cell;
			key_q   <= subscriber_id[ID_W-1:0];
			pzero_q <= pidx == '0;
		end
	end

	// control sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			iss_q       <= '0;
			chk_q       <= '0;
			chk_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= ST_OK;
			mi_q        <= '0;
			ent_q       <= '0;
			pw_q        <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (ROW_W+1)'(ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						mi_q  <= '0;
						ent_q <= '0;
						pw_q  <= '0;
						st_q  <= ST_INVALID;
						if (req_type == REQ_PUT_ENTRY) begin
							out_valid_q <= 1'b1;
							if (put_ok) begin
								st_q <= ST_OK;
							end
						end else if (req_type == REQ_GET_ENTRY) begin
							if (idx_ok) begin
								state_q <= S_RDENT;
							end else begin
								out_valid_q <= 1'b1;
							end
						end else if (req_type == REQ_LOOKUP) begin
							if (subscriber_id[31:24] != 8'd0) begin
								st_q        <= ST_NOT_FOUND;
								out_valid_q <= 1'b1;
							end else begin
								iss_q     <= '0;
								chk_vld_q <= 1'b0;
								state_q   <= S_SCAN;
							end
						end else if (req_type == REQ_PUT_PROFILE) begin
							out_valid_q <= 1'b1;
							if (pidx_ok) begin
								st_q <= (pidx == '0) ? ST_NOT_PERMITTED : ST_OK;
							end
						end else if (req_type == REQ_GET_PROFILE) begin
							if (pidx_ok) begin
								state_q <= S_RDPROF;
							end else begin
								out_valid_q <= 1'b1;
							end
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				S_RDENT: begin
					st_q        <= ST_OK;
					ent_q       <= rd_data[sel_q];
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_RDPROF: begin
					st_q <= ST_OK;
					if (pzero_q) begin
						pw_q <= pz_word_q;
					end else if (prof_rd_vld_q) begin
						pw_q <= prof_rd_q;
					end
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCAN: begin
					if (rd_en) begin
						iss_q     <= iss_q + 1'b1;
						chk_q     <= iss_q[ROW_W-1:0];
						chk_vld_q <= 1'b1;
					end else begin
						chk_vld_q <= 1'b0;
					end
					if (chk_vld_q && chain[CELLS].found) begin
						st_q        <= ST_OK;
						mi_q        <= 16'({chk_q, chain[CELLS].col});
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (chk_vld_q && chk_q == ROW_W'(ROWS - 1)) begin
						st_q        <= ST_NOT_FOUND;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid            = out_valid_q;
	assign status               = st_q;
	assign match_index          = mi_q;
	assign read_subscriber_id   = ent_q.id;
	assign read_subscriber_type = ent_q.typ;
	assign read_profile_number  = ent_q.pnum;
	assign read_reserved        = ent_q.resv;
	assign read_valid           = ent_q.valid;
	assign read_profile_word    = pw_q;

endmodule
